@@ rtl/tisqrt_pkg.sv @@
// ============================================================================
// Table-interpolated square root: shared package
// Widths, the square-root lookup table built at elaboration, and the
// payload structs that travel between the pipeline stages.
// ============================================================================
package tisqrt_pkg;

  localparam int INDEX_BITS = 8;
  localparam int FRAC_BITS  = 23;
  localparam int MANT_W     = FRAC_BITS + 1;
  localparam int EXP_W      = 8;
  localparam int WORD_W     = 32;
  localparam int ROM_DEPTH  = (1 << INDEX_BITS) + 1;
  localparam int ROM_AW     = INDEX_BITS + 1;
  localparam int PROD_W     = MANT_W + INDEX_BITS;
  localparam int WIDE_W     = 2 * MANT_W;
  localparam int SCALED_W   = MANT_W + 1;
  localparam int EXP_OFFSET = 63;

  // sqrt(2) in unsigned Q1.23.
  localparam logic [MANT_W-1:0] ROOT2_Q23 = 24'hB504F3;

  typedef logic [MANT_W-1:0] rom_t [ROM_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry i holds sqrt(1 + i/2^INDEX_BITS) in Q1.23, rounded to nearest.
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] x;
    logic [63:0] r2;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x      = (64'(1 << INDEX_BITS) + 64'(i)) << (2 * FRAC_BITS - INDEX_BITS);
      r2     = isqrt64(x << 2);
      tbl[i] = MANT_W'((r2 + 64'd1) >> 1);
    end
    return tbl;
  endfunction

  localparam rom_t SQRT_ROM = build_rom();

  typedef struct packed {
    logic                  neg;
    logic [EXP_W-1:0]      exp;
    logic [INDEX_BITS-1:0] frac_u;
    logic [MANT_W-1:0]     lo;
    logic [MANT_W-1:0]     hi;
  } lookup_t;

  typedef struct packed {
    logic              neg;
    logic [EXP_W-1:0]  exp;
    logic [MANT_W-1:0] y;
  } interp_t;

endpackage

@@ rtl/tisqrt_lookup.sv @@
// ============================================================================
// Table-interpolated square root: table lookup stage
// Splits the operand and reads the two neighboring table entries.
// ============================================================================
module tisqrt_lookup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tisqrt_pkg::WORD_W-1:0]     in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tisqrt_pkg::lookup_t               out_data
);

  logic                                 valid_r;
  tisqrt_pkg::lookup_t                  data_r;
  tisqrt_pkg::lookup_t                  data_nxt;
  logic [tisqrt_pkg::INDEX_BITS-1:0]    idx;
  logic [tisqrt_pkg::ROM_AW-1:0]        idx_lo;
  logic [tisqrt_pkg::ROM_AW-1:0]        idx_hi;

  assign in_ready = !valid_r || out_ready;

  assign idx    = in_word[tisqrt_pkg::FRAC_BITS-1 -: tisqrt_pkg::INDEX_BITS];
  assign idx_lo = {1'b0, idx};
  assign idx_hi = idx_lo + tisqrt_pkg::ROM_AW'(1);

  always_comb begin
    data_nxt.neg    = in_word[tisqrt_pkg::WORD_W-1];
    data_nxt.exp    = in_word[tisqrt_pkg::WORD_W-2 -: tisqrt_pkg::EXP_W];
    data_nxt.frac_u = in_word[tisqrt_pkg::FRAC_BITS-1-tisqrt_pkg::INDEX_BITS -:
                              tisqrt_pkg::INDEX_BITS];
    data_nxt.lo     = tisqrt_pkg::SQRT_ROM[idx_lo];
    data_nxt.hi     = tisqrt_pkg::SQRT_ROM[idx_hi];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/tisqrt_interp.sv @@
// ============================================================================
// Table-interpolated square root: interpolation stages
// Multiplies the entry difference by the fraction, then adds it to the
// lower entry. Two register stages.
// ============================================================================
module tisqrt_interp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tisqrt_pkg::lookup_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tisqrt_pkg::interp_t    out_data
);

  logic                                 mul_valid_r;
  logic                                 mul_ready;
  logic                                 mul_neg_r;
  logic [tisqrt_pkg::EXP_W-1:0]         mul_exp_r;
  logic [tisqrt_pkg::MANT_W-1:0]        mul_lo_r;
  logic [tisqrt_pkg::PROD_W-1:0]        mul_prod_r;
  logic [tisqrt_pkg::MANT_W-1:0]        diff;
  logic [tisqrt_pkg::PROD_W-1:0]        mul_prod_nxt;

  logic                                 add_valid_r;
  tisqrt_pkg::interp_t                  add_data_r;
  tisqrt_pkg::interp_t                  add_data_nxt;

  assign mul_ready = !add_valid_r || out_ready;
  assign in_ready  = !mul_valid_r || mul_ready;

  // The table is increasing, so the difference never wraps.
  assign diff         = in_data.hi - in_data.lo;
  assign mul_prod_nxt = tisqrt_pkg::PROD_W'(diff) * tisqrt_pkg::PROD_W'(in_data.frac_u);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (in_ready) begin
      mul_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_neg_r  <= in_data.neg;
      mul_exp_r  <= in_data.exp;
      mul_lo_r   <= in_data.lo;
      mul_prod_r <= mul_prod_nxt;
    end
  end

  always_comb begin
    add_data_nxt.neg = mul_neg_r;
    add_data_nxt.exp = mul_exp_r;
    add_data_nxt.y   = mul_lo_r +
                       mul_prod_r[tisqrt_pkg::PROD_W-1 -: tisqrt_pkg::MANT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_valid_r <= 1'b0;
    end else if (mul_ready) begin
      add_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid_r) begin
      add_data_r <= add_data_nxt;
    end
  end

  assign out_valid = add_valid_r;
  assign out_data  = add_data_r;

endmodule

@@ rtl/tisqrt_scale.sv @@
// ============================================================================
// Table-interpolated square root: exponent and packing stages
// Halves the exponent, scales by sqrt(2) for an odd exponent, renormalizes
// and packs the single-precision result. Two register stages.
// ============================================================================
module tisqrt_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tisqrt_pkg::interp_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tisqrt_pkg::WORD_W-1:0]     out_word,
  output logic                              out_neg
);

  logic                                 mul_valid_r;
  logic                                 mul_ready;
  logic                                 mul_neg_r;
  logic                                 mul_odd_r;
  logic [tisqrt_pkg::EXP_W-1:0]         mul_exp_r;
  logic [tisqrt_pkg::MANT_W-1:0]        mul_y_r;
  logic [tisqrt_pkg::WIDE_W-1:0]        mul_wide_r;
  logic [tisqrt_pkg::EXP_W:0]           exp_inc;
  logic [tisqrt_pkg::EXP_W-1:0]         exp_nxt;
  logic [tisqrt_pkg::WIDE_W-1:0]        wide_nxt;

  logic                                 pk_valid_r;
  logic [tisqrt_pkg::WORD_W-1:0]        pk_word_r;
  logic [tisqrt_pkg::WORD_W-1:0]        pk_word_nxt;
  logic                                 pk_neg_r;
  logic [tisqrt_pkg::SCALED_W-1:0]      scaled;
  logic [tisqrt_pkg::EXP_W-1:0]         exp_fin;
  logic [tisqrt_pkg::FRAC_BITS-1:0]     mant_fin;

  assign mul_ready = !pk_valid_r || out_ready;
  assign in_ready  = !mul_valid_r || mul_ready;

  // Biased result exponent: floor((e - 127) / 2) + 127.
  assign exp_inc  = {1'b0, in_data.exp} + (tisqrt_pkg::EXP_W + 1)'(1);
  assign exp_nxt  = tisqrt_pkg::EXP_W'(exp_inc >> 1) +
                    tisqrt_pkg::EXP_W'(tisqrt_pkg::EXP_OFFSET);
  assign wide_nxt = tisqrt_pkg::WIDE_W'(in_data.y) *
                    tisqrt_pkg::WIDE_W'(tisqrt_pkg::ROOT2_Q23);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (in_ready) begin
      mul_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_neg_r  <= in_data.neg;
      // An even biased exponent is an odd unbiased one.
      mul_odd_r  <= !in_data.exp[0];
      mul_exp_r  <= exp_nxt;
      mul_y_r    <= in_data.y;
      mul_wide_r <= wide_nxt;
    end
  end

  assign scaled = mul_wide_r[tisqrt_pkg::FRAC_BITS +: tisqrt_pkg::SCALED_W];

  always_comb begin
    exp_fin  = mul_exp_r;
    mant_fin = mul_y_r[tisqrt_pkg::FRAC_BITS-1:0];
    if (mul_odd_r) begin
      if (scaled[tisqrt_pkg::SCALED_W-1]) begin
        mant_fin = scaled[tisqrt_pkg::FRAC_BITS:1];
        exp_fin  = mul_exp_r + tisqrt_pkg::EXP_W'(1);
      end else begin
        mant_fin = scaled[tisqrt_pkg::FRAC_BITS-1:0];
      end
    end
    if (mul_neg_r) begin
      pk_word_nxt = '0;
    end else begin
      pk_word_nxt = {1'b0, exp_fin, mant_fin};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_valid_r <= 1'b0;
    end else if (mul_ready) begin
      pk_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid_r) begin
      pk_word_r <= pk_word_nxt;
      pk_neg_r  <= mul_neg_r;
    end
  end

  assign out_valid = pk_valid_r;
  assign out_word  = pk_word_r;
  assign out_neg   = pk_neg_r;

endmodule

@@ rtl/table_interpolated_square_root.sv @@
// Throughput: one item per cycle while out_tready is high. Five register
// stages (table read, fraction multiply, add, sqrt(2) multiply, pack) lie
// between input and output, each with its own valid bit.
// A stage holds while the one after it is full and stalled, so back-pressure
// loses nothing. Synchronous active-low reset empties all stages.
// ============================================================================
// Table-interpolated square root: top level
// Single-precision square root by table lookup and linear interpolation.
// ============================================================================
module table_interpolated_square_root (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tisqrt_pkg::WORD_W-1:0]      in_tdata,   // [31:0] operand_bits
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tisqrt_pkg::WORD_W-1:0]      out_tdata,  // [31:0] root_bits
  output logic                               out_tuser   // [0] negative_input
);

  logic                   lk_valid;
  logic                   lk_ready;
  tisqrt_pkg::lookup_t    lk_data;
  logic                   ip_valid;
  logic                   ip_ready;
  tisqrt_pkg::interp_t    ip_data;

  tisqrt_lookup u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_tdata),
    .out_valid (lk_valid),
    .out_ready (lk_ready),
    .out_data  (lk_data)
  );

  tisqrt_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_data   (lk_data),
    .out_valid (ip_valid),
    .out_ready (ip_ready),
    .out_data  (ip_data)
  );

  tisqrt_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ip_valid),
    .in_ready  (ip_ready),
    .in_data   (ip_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_neg   (out_tuser)
  );

endmodule
